// ===== design/dhcp_reply_parser_core_assert.svh =====
// Assertion macros for the DHCP reply parser checker.
`ifndef DHCP_REPLY_PARSER_CORE_ASSERT_SVH
`define DHCP_REPLY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DRP_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dhcprp_pkg.sv =====
// Shared types, constants and helpers for the DHCP reply parser.
`default_nettype none
package dhcprp_pkg;

    // Fixed header layout
    localparam logic [7:0]  HDR_LEN         = 8'd240;
    localparam logic [7:0]  POS_OP          = 8'd0;
    localparam logic [7:0]  POS_XID_LAST    = 8'd7;
    localparam logic [7:0]  POS_YIADDR_LAST = 8'd19;
    localparam logic [7:0]  POS_COOKIE_LAST = 8'd239;
    localparam logic [7:0]  OP_REPLY        = 8'd2;
    localparam logic [31:0] MAGIC_COOKIE    = 32'h6382_5363;
    localparam logic [31:0] LEASE_DEFAULT   = 32'd3600;

    // Option kinds
    localparam logic [7:0] KIND_PAD    = 8'd0;
    localparam logic [7:0] KIND_END    = 8'd255;
    localparam logic [7:0] KIND_TYPE   = 8'd53;
    localparam logic [7:0] KIND_LEASE  = 8'd51;
    localparam logic [7:0] KIND_MASK   = 8'd1;
    localparam logic [7:0] KIND_ROUTER = 8'd3;
    localparam logic [7:0] KIND_DNS    = 8'd6;

    // Usable option lengths
    localparam logic [7:0] LEN_TYPE = 8'd1;
    localparam logic [7:0] LEN_ADDR = 8'd4;

    // Message types
    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK   = 8'd5;
    localparam logic [7:0] MSG_NAK   = 8'd6;

    // Tracked option slots, one bit each
    localparam int unsigned SLOTS       = 5;
    localparam int unsigned SLOT_TYPE   = 0;
    localparam int unsigned SLOT_LEASE  = 1;
    localparam int unsigned SLOT_MASK   = 2;
    localparam int unsigned SLOT_ROUTER = 3;
    localparam int unsigned SLOT_DNS    = 4;

    // Configuration register byte addresses
    localparam int unsigned ADDR_W   = 3;
    localparam logic [ADDR_W-1:0] ADDR_XID = 3'd0;

    typedef logic [SLOTS-1:0] slot_mask_t;

    typedef enum logic [1:0] {
        ACT_IGNORE = 2'd0,
        ACT_OFFER  = 2'd1,
        ACT_ACK    = 2'd2,
        ACT_NAK    = 2'd3
    } action_t;

    // Option state after the current byte, as seen by the result logic
    typedef struct packed {
        slot_mask_t  found;
        logic [7:0]  msg_type;
        logic [31:0] lease;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
    } opt_info_t;

    // One-hot slot for a tracked option kind, zero for anything else
    function automatic slot_mask_t slot_of(input logic [7:0] kind);
        slot_mask_t m;
        m = '0;
        unique case (kind)
            KIND_TYPE:   m[SLOT_TYPE]   = 1'b1;
            KIND_LEASE:  m[SLOT_LEASE]  = 1'b1;
            KIND_MASK:   m[SLOT_MASK]   = 1'b1;
            KIND_ROUTER: m[SLOT_ROUTER] = 1'b1;
            KIND_DNS:    m[SLOT_DNS]    = 1'b1;
            default:     m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== design/dhcprp_opt_walker.sv =====
// Option TLV walker: tracks first occurrence of the five options of interest.
`default_nettype none
module dhcprp_opt_walker (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic                   clear,
    input  wire logic [7:0]             data_byte,
    output dhcprp_pkg::opt_info_t       info
);

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    phase_t                  phase_reg,    phase_next;
    logic [7:0]              code_reg,     code_next;
    logic [7:0]              left_reg,     left_next;
    logic [31:0]             gather_reg,   gather_next;
    dhcprp_pkg::slot_mask_t  decided_reg,  decided_next;
    dhcprp_pkg::slot_mask_t  found_reg,    found_next;
    logic [7:0]              msg_reg,      msg_next;
    logic [31:0]             lease_reg,    lease_next;
    logic [31:0]             mask_reg,     mask_next;
    logic [31:0]             router_reg,   router_next;
    logic [31:0]             dns_reg,      dns_next;

    dhcprp_pkg::slot_mask_t  cur_slot;
    logic [7:0]              need_len;
    logic [31:0]             shifted;
    logic [7:0]              left_dec;

    assign cur_slot = dhcprp_pkg::slot_of(code_reg);
    assign need_len = cur_slot[dhcprp_pkg::SLOT_TYPE] ? dhcprp_pkg::LEN_TYPE
                                                      : dhcprp_pkg::LEN_ADDR;
    assign shifted  = {gather_reg[23:0], data_byte};
    assign left_dec = left_reg - 8'd1;

    // Per-byte walk
    always_comb
    begin
        phase_next   = phase_reg;
        code_next    = code_reg;
        left_next    = left_reg;
        gather_next  = gather_reg;
        decided_next = decided_reg;
        found_next   = found_reg;
        msg_next     = msg_reg;
        lease_next   = lease_reg;
        mask_next    = mask_reg;
        router_next  = router_reg;
        dns_next     = dns_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_KIND:
                begin
                    if (data_byte == dhcprp_pkg::KIND_END)
                        phase_next = PH_STOP;
                    else if (data_byte != dhcprp_pkg::KIND_PAD)
                    begin
                        code_next  = data_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    // first occurrence with a wrong length decides the option as absent
                    if ((cur_slot & ~decided_reg) != '0 && data_byte != need_len)
                        decided_next = decided_reg | cur_slot;
                    if (data_byte == 8'd0)
                        phase_next = PH_KIND;
                    else
                    begin
                        left_next   = data_byte;
                        gather_next = '0;
                        phase_next  = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    gather_next = shifted;
                    left_next   = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        if ((cur_slot & ~decided_reg) != '0)
                        begin
                            decided_next = decided_reg | cur_slot;
                            found_next   = found_reg | cur_slot;
                            if (cur_slot[dhcprp_pkg::SLOT_TYPE])   msg_next    = shifted[7:0];
                            if (cur_slot[dhcprp_pkg::SLOT_LEASE])  lease_next  = shifted;
                            if (cur_slot[dhcprp_pkg::SLOT_MASK])   mask_next   = shifted;
                            if (cur_slot[dhcprp_pkg::SLOT_ROUTER]) router_next = shifted;
                            if (cur_slot[dhcprp_pkg::SLOT_DNS])    dns_next    = shifted;
                        end
                        phase_next = PH_KIND;
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_KIND;
                end
            endcase
        end
    end

    // View including the current byte, for the final-byte decision
    always_comb
    begin
        info.found    = found_next;
        info.msg_type = msg_next;
        info.lease    = lease_next;
        info.mask     = mask_next;
        info.router   = router_next;
        info.dns      = dns_next;
    end

    // State, cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n || clear)
        begin
            if (!rst_n || clear)
            begin
                phase_reg   <= PH_KIND;
                code_reg    <= '0;
                left_reg    <= '0;
                gather_reg  <= '0;
                decided_reg <= '0;
                found_reg   <= '0;
                msg_reg     <= '0;
                lease_reg   <= '0;
                mask_reg    <= '0;
                router_reg  <= '0;
                dns_reg     <= '0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            code_reg    <= code_next;
            left_reg    <= left_next;
            gather_reg  <= gather_next;
            decided_reg <= decided_next;
            found_reg   <= found_next;
            msg_reg     <= msg_next;
            lease_reg   <= lease_next;
            mask_reg    <= mask_next;
            router_reg  <= router_next;
            dns_reg     <= dns_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/dhcp_reply_parser_core.sv =====
// One result item is registered in the cycle after its final payload byte is accepted.
// Throughput: one payload byte per cycle while not stalled; every stage is a single registered pass per byte.
// A final byte is held off only while the previous result is still stalled at the output.
// Reset (rst_n low, asynchronous): header/option walk cleared, xid, kept offer data zeroed.
// Top level of the DHCP client reply parser.
`default_nettype none
module dhcp_reply_parser_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // byte stream in
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         payload_byte,
    input  wire logic                               final_byte,
    input  wire logic [31:0]                        sender_address,
    // result out
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              action,
    output logic [31:0]                             assigned_address,
    output logic [31:0]                             server_address,
    output logic [31:0]                             lease_seconds,
    output logic [31:0]                             subnet_mask,
    output logic [31:0]                             gateway_address,
    output logic [31:0]                             name_server,
    output logic                                    mask_present,
    output logic                                    gateway_present,
    output logic                                    name_server_present,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dhcprp_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    logic                  in_accept;
    logic                  last_accept;
    logic                  hdr_active;
    logic [31:0]           shift_cat;

    logic [31:0]           xid_reg;
    logic [7:0]            hpos_reg,    hpos_next;
    logic                  hvalid_reg,  hvalid_next;
    logic [31:0]           hshift_reg,  hshift_next;
    logic [31:0]           yaddr_reg,   yaddr_next;
    logic [31:0]           kserver_reg, kserver_next;
    logic [31:0]           klease_reg,  klease_next;

    logic                  out_valid_reg;
    dhcprp_pkg::action_t   act_reg,     act_next;
    logic [31:0]           assigned_reg, assigned_next;
    logic [31:0]           server_reg,   server_next;
    logic [31:0]           lease_reg,    lease_next;
    logic [31:0]           smask_reg,    smask_next;
    logic [31:0]           gw_reg,       gw_next;
    logic [31:0]           ns_reg,       ns_next;
    logic                  smask_p_reg,  smask_p_next;
    logic                  gw_p_reg,     gw_p_next;
    logic                  ns_p_reg,     ns_p_next;

    logic                  type_ok;
    dhcprp_pkg::opt_info_t opt;

    // Handshake: only a final byte needs a free result slot
    assign in_stall    = out_valid_reg && out_stall && final_byte;
    assign in_accept   = in_valid && !in_stall;
    assign last_accept = in_accept && final_byte;
    assign hdr_active  = hpos_reg < dhcprp_pkg::HDR_LEN;
    assign shift_cat   = {hshift_reg[23:0], payload_byte};

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == dhcprp_pkg::ADDR_XID) ? xid_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xid_reg <= '0;
        else if (psel && penable && pwrite && paddr == dhcprp_pkg::ADDR_XID)
            xid_reg <= pwdata;
    end

    // Option walker
    dhcprp_opt_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_accept && !hdr_active),
        .clear     (last_accept),
        .data_byte (payload_byte),
        .info      (opt)
    );

    // Fixed header checks
    always_comb
    begin
        hpos_next   = hpos_reg;
        hvalid_next = hvalid_reg;
        hshift_next = hshift_reg;
        yaddr_next  = yaddr_reg;
        if (in_accept && hdr_active)
        begin
            hpos_next   = hpos_reg + 8'd1;
            hshift_next = shift_cat;
            if (hpos_reg == dhcprp_pkg::POS_OP && payload_byte != dhcprp_pkg::OP_REPLY)
                hvalid_next = 1'b0;
            if (hpos_reg == dhcprp_pkg::POS_XID_LAST && shift_cat != xid_reg)
                hvalid_next = 1'b0;
            if (hpos_reg == dhcprp_pkg::POS_YIADDR_LAST)
                yaddr_next = shift_cat;
            if (hpos_reg == dhcprp_pkg::POS_COOKIE_LAST && shift_cat != dhcprp_pkg::MAGIC_COOKIE)
                hvalid_next = 1'b0;
        end
    end

    // Final-byte decision
    assign type_ok = hpos_next == dhcprp_pkg::HDR_LEN && hvalid_next
                     && opt.found[dhcprp_pkg::SLOT_TYPE];

    always_comb
    begin
        kserver_next  = kserver_reg;
        klease_next   = klease_reg;
        act_next      = dhcprp_pkg::ACT_IGNORE;
        assigned_next = '0;
        server_next   = '0;
        lease_next    = '0;
        smask_next    = '0;
        gw_next       = '0;
        ns_next       = '0;
        smask_p_next  = 1'b0;
        gw_p_next     = 1'b0;
        ns_p_next     = 1'b0;
        if (type_ok)
        begin
            priority if (opt.msg_type == dhcprp_pkg::MSG_OFFER)
            begin
                kserver_next  = sender_address;
                klease_next   = opt.found[dhcprp_pkg::SLOT_LEASE] ? opt.lease
                                                                  : dhcprp_pkg::LEASE_DEFAULT;
                act_next      = dhcprp_pkg::ACT_OFFER;
                assigned_next = yaddr_next;
                server_next   = kserver_next;
                lease_next    = klease_next;
            end
            else if (opt.msg_type == dhcprp_pkg::MSG_ACK)
            begin
                act_next      = dhcprp_pkg::ACT_ACK;
                assigned_next = yaddr_next;
                server_next   = kserver_reg;
                lease_next    = klease_reg;
                smask_p_next  = opt.found[dhcprp_pkg::SLOT_MASK];
                gw_p_next     = opt.found[dhcprp_pkg::SLOT_ROUTER];
                ns_p_next     = opt.found[dhcprp_pkg::SLOT_DNS];
                smask_next    = smask_p_next ? opt.mask   : 32'd0;
                gw_next       = gw_p_next    ? opt.router : 32'd0;
                ns_next       = ns_p_next    ? opt.dns    : 32'd0;
            end
            else if (opt.msg_type == dhcprp_pkg::MSG_NAK)
                act_next = dhcprp_pkg::ACT_NAK;
            else
                act_next = dhcprp_pkg::ACT_IGNORE;
        end
    end

    // Header state and kept offer data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpos_reg    <= '0;
            hvalid_reg  <= 1'b1;
            hshift_reg  <= '0;
            yaddr_reg   <= '0;
            kserver_reg <= '0;
            klease_reg  <= '0;
        end
        else if (last_accept)
        begin
            hpos_reg    <= '0;
            hvalid_reg  <= 1'b1;
            hshift_reg  <= '0;
            yaddr_reg   <= '0;
            kserver_reg <= kserver_next;
            klease_reg  <= klease_next;
        end
        else
        begin
            hpos_reg    <= hpos_next;
            hvalid_reg  <= hvalid_next;
            hshift_reg  <= hshift_next;
            yaddr_reg   <= yaddr_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (last_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (last_accept)
        begin
            act_reg      <= act_next;
            assigned_reg <= assigned_next;
            server_reg   <= server_next;
            lease_reg    <= lease_next;
            smask_reg    <= smask_next;
            gw_reg       <= gw_next;
            ns_reg       <= ns_next;
            smask_p_reg  <= smask_p_next;
            gw_p_reg     <= gw_p_next;
            ns_p_reg     <= ns_p_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign action              = act_reg;
    assign assigned_address    = assigned_reg;
    assign server_address      = server_reg;
    assign lease_seconds       = lease_reg;
    assign subnet_mask         = smask_reg;
    assign gateway_address     = gw_reg;
    assign name_server         = ns_reg;
    assign mask_present        = smask_p_reg;
    assign gateway_present     = gw_p_reg;
    assign name_server_present = ns_p_reg;

endmodule
`default_nettype wire

// ===== design/dhcprp_checker.sv =====
// Port-level checker for the DHCP reply parser, bound to the top level.
`default_nettype none
`include "dhcp_reply_parser_core_assert.svh"
module dhcprp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        final_byte,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  action,
    input wire logic [31:0] assigned_address,
    input wire logic [31:0] server_address,
    input wire logic [31:0] lease_seconds,
    input wire logic [31:0] subnet_mask,
    input wire logic [31:0] gateway_address,
    input wire logic [31:0] name_server,
    input wire logic        mask_present,
    input wire logic        gateway_present,
    input wire logic        name_server_present
);

    logic opts_clear;
    logic addr_clear;

    assign opts_clear = subnet_mask == 32'd0 && gateway_address == 32'd0
                        && name_server == 32'd0 && !mask_present
                        && !gateway_present && !name_server_present;
    assign addr_clear = assigned_address == 32'd0 && server_address == 32'd0
                        && lease_seconds == 32'd0;

    // A stalled result stays offered
    `DRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    // An accepted final byte always yields a result next cycle
    `DRP_ASSERT_NEXT(a_final_result, clk, rst_n, in_valid && !in_stall && final_byte, out_valid, "final byte without result")

    // Ignored and nak results carry nothing else
    `DRP_ASSERT_SAME(a_empty_result, clk, rst_n, out_valid && (action == dhcprp_pkg::ACT_IGNORE || action == dhcprp_pkg::ACT_NAK), opts_clear && addr_clear, "ignore/nak with payload")

    // Offers never report ack options
    `DRP_ASSERT_SAME(a_offer_opts, clk, rst_n, out_valid && action == dhcprp_pkg::ACT_OFFER, opts_clear, "offer with ack options")

endmodule

bind dhcp_reply_parser_core dhcprp_checker u_dhcprp_checker (.*);
`default_nettype wire

// ===== verif/tb_dhcp_reply_parser_core.sv =====
// Self-checking testbench for the DHCP reply parser core: byte stream in, one result per reply.
module tb_dhcp_reply_parser_core;
    import dhcprp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 4;

    // one payload byte as it travels on the input channel
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] src;
    } byte_item_t;

    // one result item
    typedef struct packed {
        action_t     action;
        logic [31:0] assigned_address;
        logic [31:0] server_address;
        logic [31:0] lease_seconds;
        logic [31:0] subnet_mask;
        logic [31:0] gateway_address;
        logic [31:0] name_server;
        logic        mask_present;
        logic        gateway_present;
        logic        name_server_present;
    } reply_t;

    typedef enum logic [1:0] {SEEK_KIND, SEEK_LEN, IN_DATA, STOPPED} walk_t;

    typedef enum int {P_TYPE, P_LEASE, P_MASK, P_ROUTER, P_DNS, P_OTHER, P_PADS, P_REPEAT} piece_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  payload_byte = '0;
    logic        final_byte = 1'b0;
    logic [31:0] sender_address = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  action;
    logic [31:0] assigned_address;
    logic [31:0] server_address;
    logic [31:0] lease_seconds;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_address;
    logic [31:0] name_server;
    logic        mask_present;
    logic        gateway_present;
    logic        name_server_present;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    dhcp_reply_parser_core i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .payload_byte        (payload_byte),
        .final_byte          (final_byte),
        .sender_address      (sender_address),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .action              (action),
        .assigned_address    (assigned_address),
        .server_address      (server_address),
        .lease_seconds       (lease_seconds),
        .subnet_mask         (subnet_mask),
        .gateway_address     (gateway_address),
        .name_server         (name_server),
        .mask_present        (mask_present),
        .gateway_present     (gateway_present),
        .name_server_present (name_server_present),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #2 clk = ~clk;

    // stimulus and scoreboard storage
    byte_item_t  byte_backlog[$];
    reply_t      expected_replies[$];
    logic [7:0]  frame[$];
    int          errors = 0;
    int          cycle_count = 0;
    logic        calm = 1'b0;
    int          hold_requests = 0;

    // parser mirror: configuration, per-packet walk state, offer memory
    logic [31:0] xid_reg;
    logic [7:0]  hdr_pos;
    logic        hdr_ok;
    logic [31:0] hdr_shift;
    logic [31:0] yiaddr;
    walk_t       walk;
    logic [7:0]  opt_kind;
    logic [7:0]  opt_left;
    logic [31:0] opt_gather;
    slot_mask_t  decided;
    slot_mask_t  found;
    logic [31:0] opt_val [SLOTS];
    logic [31:0] offer_server;
    logic [31:0] offer_lease;

    function automatic int slot_for(logic [7:0] kind);
        case (kind)
            KIND_TYPE:   return SLOT_TYPE;
            KIND_LEASE:  return SLOT_LEASE;
            KIND_MASK:   return SLOT_MASK;
            KIND_ROUTER: return SLOT_ROUTER;
            KIND_DNS:    return SLOT_DNS;
            default:     return SLOTS;
        endcase
    endfunction

    function automatic void clear_walk();
        hdr_pos = '0;
        hdr_ok = 1'b1;
        hdr_shift = '0;
        yiaddr = '0;
        walk = SEEK_KIND;
        opt_kind = '0;
        opt_left = '0;
        opt_gather = '0;
        decided = '0;
        found = '0;
        for (int i = 0; i < SLOTS; i++)
            opt_val[i] = '0;
    endfunction

    // Advance the mirror by one accepted byte; a final byte queues the expected result.
    function automatic void parse_reply_byte(byte_item_t it);
        int     s;
        reply_t r;
        logic [7:0] b;
        b = it.data;
        if (hdr_pos < HDR_LEN) begin
            hdr_shift = {hdr_shift[23:0], b};
            if (hdr_pos == POS_OP && b != OP_REPLY) hdr_ok = 1'b0;
            if (hdr_pos == POS_XID_LAST && hdr_shift != xid_reg) hdr_ok = 1'b0;
            if (hdr_pos == POS_YIADDR_LAST) yiaddr = hdr_shift;
            if (hdr_pos == POS_COOKIE_LAST && hdr_shift != MAGIC_COOKIE) hdr_ok = 1'b0;
            hdr_pos = hdr_pos + 8'd1;
        end else begin
            case (walk)
                SEEK_KIND: begin
                    if (b == KIND_END)
                        walk = STOPPED;
                    else if (b != KIND_PAD) begin
                        opt_kind = b;
                        walk = SEEK_LEN;
                    end
                end
                SEEK_LEN: begin
                    // first occurrence decides, even with an unusable length
                    s = slot_for(opt_kind);
                    if (s < SLOTS && !decided[s] && b != ((s == SLOT_TYPE) ? LEN_TYPE : LEN_ADDR))
                        decided[s] = 1'b1;
                    if (b == 8'd0)
                        walk = SEEK_KIND;
                    else begin
                        opt_left = b;
                        opt_gather = '0;
                        walk = IN_DATA;
                    end
                end
                IN_DATA: begin
                    opt_gather = {opt_gather[23:0], b};
                    opt_left = opt_left - 8'd1;
                    if (opt_left == 8'd0) begin
                        s = slot_for(opt_kind);
                        if (s < SLOTS && !decided[s]) begin
                            decided[s] = 1'b1;
                            found[s] = 1'b1;
                            opt_val[s] = opt_gather;
                        end
                        walk = SEEK_KIND;
                    end
                end
                default: ;
            endcase
        end

        if (!it.last) return;

        r = '0;
        r.action = ACT_IGNORE;
        if (hdr_pos == HDR_LEN && hdr_ok && found[SLOT_TYPE]) begin
            case (opt_val[SLOT_TYPE][7:0])
                MSG_OFFER: begin
                    offer_server = it.src;
                    offer_lease = found[SLOT_LEASE] ? opt_val[SLOT_LEASE] : LEASE_DEFAULT;
                    r.action = ACT_OFFER;
                    r.assigned_address = yiaddr;
                    r.server_address = offer_server;
                    r.lease_seconds = offer_lease;
                end
                MSG_ACK: begin
                    r.action = ACT_ACK;
                    r.assigned_address = yiaddr;
                    r.server_address = offer_server;
                    r.lease_seconds = offer_lease;
                    if (found[SLOT_MASK]) begin
                        r.subnet_mask = opt_val[SLOT_MASK];
                        r.mask_present = 1'b1;
                    end
                    if (found[SLOT_ROUTER]) begin
                        r.gateway_address = opt_val[SLOT_ROUTER];
                        r.gateway_present = 1'b1;
                    end
                    if (found[SLOT_DNS]) begin
                        r.name_server = opt_val[SLOT_DNS];
                        r.name_server_present = 1'b1;
                    end
                end
                MSG_NAK: r.action = ACT_NAK;
                default: ;
            endcase
        end
        expected_replies.push_back(r);
        clear_walk();
    endfunction

    // ---------------- frame building ----------------

    function automatic void add_noise(int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    function automatic void add_pads(int n);
        repeat (n) frame.push_back(KIND_PAD);
    endfunction

    function automatic void add_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            frame.push_back(w[8*i +: 8]);
    endfunction

    // short options carry the low bytes of val, most significant first
    function automatic void add_opt(logic [7:0] kind, logic [7:0] len, logic [31:0] val);
        frame.push_back(kind);
        frame.push_back(len);
        for (int i = 0; i < len; i++) begin
            if (len <= 8'd4)
                frame.push_back(val[8*(len-1-i) +: 8]);
            else
                frame.push_back(8'($urandom));
        end
    endfunction

    function automatic void start_frame(logic [7:0] op, logic [31:0] xid, logic [31:0] yi,
                                        logic [31:0] cookie);
        frame.delete();
        frame.push_back(op);
        add_noise(3);
        add_word(xid);
        add_noise(8);
        add_word(yi);
        add_noise(216);
        add_word(cookie);
    endfunction

    function automatic void send_frame(logic [31:0] src);
        byte_item_t it;
        foreach (frame[i]) begin
            it.data = frame[i];
            it.last = (i == frame.size() - 1);
            it.src = src;
            byte_backlog.push_back(it);
        end
    endfunction

    // tracked option, usually with its usable length
    function automatic void add_tracked(logic [7:0] kind, logic [7:0] good, logic [31:0] val);
        logic [7:0] len;
        len = good;
        if ($urandom_range(0, 7) == 0) begin
            len = 8'($urandom_range(0, 6));
            if (len == good) len = 8'd0;
        end
        add_opt(kind, len, val);
    endfunction

    function automatic logic [7:0] random_msg();
        case ($urandom_range(0, 9))
            0, 1, 2: return MSG_OFFER;
            3, 4, 5: return MSG_ACK;
            6, 7:    return MSG_NAK;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_random_options(logic [7:0] msg);
        piece_t order[$];
        logic [7:0] kind;
        if ($urandom_range(0, 9) != 0) order.push_back(P_TYPE);
        if ($urandom_range(0, 1) != 0) order.insert($urandom_range(0, order.size()), P_LEASE);
        if ($urandom_range(0, 4) > 1) order.insert($urandom_range(0, order.size()), P_MASK);
        if ($urandom_range(0, 4) > 1) order.insert($urandom_range(0, order.size()), P_ROUTER);
        if ($urandom_range(0, 4) > 1) order.insert($urandom_range(0, order.size()), P_DNS);
        repeat ($urandom_range(0, 2)) order.insert($urandom_range(0, order.size()), P_OTHER);
        repeat ($urandom_range(0, 2)) order.insert($urandom_range(0, order.size()), P_PADS);
        if ($urandom_range(0, 2) == 0) order.insert($urandom_range(0, order.size()), P_REPEAT);

        foreach (order[i]) begin
            case (order[i])
                P_TYPE:   add_tracked(KIND_TYPE, LEN_TYPE, {24'd0, msg});
                P_LEASE:  add_tracked(KIND_LEASE, LEN_ADDR, $urandom);
                P_MASK:   add_tracked(KIND_MASK, LEN_ADDR, $urandom);
                P_ROUTER: add_tracked(KIND_ROUTER, LEN_ADDR, $urandom);
                P_DNS:    add_tracked(KIND_DNS, LEN_ADDR, $urandom);
                P_OTHER: begin
                    kind = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(7, 50))
                                                       : 8'($urandom_range(54, 254));
                    add_opt(kind, 8'($urandom_range(0, 6)), $urandom);
                end
                P_PADS:   add_pads($urandom_range(1, 4));
                default: begin
                    // a second occurrence of some tracked option
                    case ($urandom_range(0, 4))
                        0: add_tracked(KIND_TYPE, LEN_TYPE, {24'd0, random_msg()});
                        1: add_tracked(KIND_LEASE, LEN_ADDR, $urandom);
                        2: add_tracked(KIND_MASK, LEN_ADDR, $urandom);
                        3: add_tracked(KIND_ROUTER, LEN_ADDR, $urandom);
                        default: add_tracked(KIND_DNS, LEN_ADDR, $urandom);
                    endcase
                end
            endcase
        end

        // end mark, sometimes with trailing bytes that must be ignored
        if ($urandom_range(0, 9) < 7) begin
            frame.push_back(KIND_END);
            add_noise($urandom_range(0, 6));
        end
    endfunction

    function automatic void random_frame();
        int          pick;
        int          n;
        logic [7:0]  op;
        logic [31:0] hx;
        logic [31:0] ck;
        pick = $urandom_range(0, 99);
        // short packet
        if (pick < 12) begin
            frame.delete();
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 239) : $urandom_range(1, 12);
            add_noise(n);
            return;
        end
        op = OP_REPLY;
        hx = xid_reg;
        ck = MAGIC_COOKIE;
        // single-bit header corruption
        if (pick < 24) begin
            case ($urandom_range(0, 2))
                0: op[$urandom_range(0, 7)] = ~op[$urandom_range(0, 7)];
                1: hx = hx ^ (32'd1 << $urandom_range(0, 31));
                default: ck = ck ^ (32'd1 << $urandom_range(0, 31));
            endcase
            if (op == OP_REPLY) op = op ^ 8'h80;
        end
        start_frame(op, hx, $urandom, ck);
        if (pick >= 94) begin
            add_noise($urandom_range(1, 40));
            return;
        end
        add_random_options(random_msg());
        // truncated reply
        if ($urandom_range(0, 4) == 0 && frame.size() > 241) begin
            n = $urandom_range(241, frame.size() - 1);
            while (frame.size() > n) void'(frame.pop_back());
        end
    endfunction

    // ---------------- driver ----------------

    int send_gap = 0;
    int send_mode_left = 0;
    bit send_idle_on = 1'b1;
    byte_item_t next_item;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            clear_walk();
            xid_reg = '0;
            offer_server = '0;
            offer_lease = '0;
        end else begin
            if (in_valid && !in_stall)
                parse_reply_byte('{payload_byte, final_byte, sender_address});

            if (send_mode_left == 0) begin
                send_idle_on = ($urandom_range(0, 2) != 0);
                send_mode_left = $urandom_range(20, 200);
            end else
                send_mode_left--;

            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (!calm && send_idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end else if (byte_backlog.size() != 0) begin
                    next_item = byte_backlog.pop_front();
                    in_valid <= 1'b1;
                    payload_byte <= next_item.data;
                    final_byte <= next_item.last;
                    sender_address <= next_item.src;
                end else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stall ----------------

    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int recv_mode_left = 0;
    bit recv_idle_on = 1'b1;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else begin
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (recv_mode_left == 0) begin
                recv_idle_on = ($urandom_range(0, 2) != 0);
                recv_mode_left = $urandom_range(20, 200);
            end else
                recv_mode_left--;

            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!calm && recv_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end else
                out_stall <= 1'b0;
        end
    end

    // ---------------- monitor ----------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    reply_t want;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual action %0d",
                         $time, action);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                check_field("action", 32'(want.action), 32'(action));
                check_field("assigned_address", want.assigned_address, assigned_address);
                check_field("server_address", want.server_address, server_address);
                check_field("lease_seconds", want.lease_seconds, lease_seconds);
                check_field("subnet_mask", want.subnet_mask, subnet_mask);
                check_field("gateway_address", want.gateway_address, gateway_address);
                check_field("name_server", want.name_server, name_server);
                check_field("mask_present", 32'(want.mask_present), 32'(mask_present));
                check_field("gateway_present", 32'(want.gateway_present), 32'(gateway_present));
                check_field("name_server_present", 32'(want.name_server_present),
                            32'(name_server_present));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dhcp_reply_parser_core regression: fail");
            $finish;
        end
    end

    // ---------------- sequencing ----------------

    // nothing queued, nothing in flight, nothing owed, held over a run of quiet cycles
    task automatic wait_drained();
        int settle;
        settle = 0;
        while (settle < SETTLE) begin
            @(negedge clk);
            if (byte_backlog.size() == 0 && !in_valid && expected_replies.size() == 0)
                settle++;
            else
                settle = 0;
        end
    endtask

    task automatic write_xid(logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_XID;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        xid_reg = v;
    endtask

    task automatic random_phase(int min_bytes, int min_frames);
        int nbytes;
        int nframes;
        nbytes = 0;
        nframes = 0;
        @(negedge clk);
        while (nbytes < min_bytes || nframes < min_frames) begin
            random_frame();
            nbytes += frame.size();
            nframes++;
            send_frame($urandom);
        end
        wait_drained();
    endtask

    task automatic directed_frames();
        @(negedge clk);
        // offer with lease; an offer reports no options
        start_frame(OP_REPLY, xid_reg, 32'hFFFF_FFFF, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_OFFER);
        add_opt(KIND_LEASE, LEN_ADDR, 32'h0001_5180);
        add_opt(KIND_MASK, LEN_ADDR, 32'hFFFF_FF00);
        frame.push_back(KIND_END);
        send_frame(32'hFFFF_FFFF);
        // full ack with pads; a nak after the end mark is ignored
        start_frame(OP_REPLY, xid_reg, 32'h0A00_0005, MAGIC_COOKIE);
        add_pads(2);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        add_opt(KIND_MASK, LEN_ADDR, 32'h0000_0000);
        add_pads(1);
        add_opt(KIND_ROUTER, LEN_ADDR, 32'hFFFF_FFFF);
        add_opt(KIND_DNS, LEN_ADDR, 32'h0808_0808);
        frame.push_back(KIND_END);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_NAK);
        send_frame(32'h0000_0000);
        // ack with only the type, final byte on the type value
        start_frame(OP_REPLY, xid_reg, 32'h0000_0000, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        send_frame($urandom);
        // offer without lease falls back to the default
        start_frame(OP_REPLY, xid_reg, 32'hC0A8_0164, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_OFFER);
        frame.push_back(KIND_END);
        send_frame(32'hC0A8_0001);
        // nak clears every field
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_MASK, LEN_ADDR, $urandom);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_NAK);
        send_frame($urandom);
        // unknown message types
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, 32'd1);
        send_frame($urandom);
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, 32'd255);
        send_frame($urandom);
        // no type at all
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_MASK, LEN_ADDR, $urandom);
        frame.push_back(KIND_END);
        send_frame($urandom);
        // type with unusable length
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, 8'd2, {16'd0, MSG_ACK, MSG_ACK});
        send_frame($urandom);
        // zero-length type decides it, the later good one is ignored
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, 8'd0, 32'd0);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        send_frame($urandom);
        // ack: empty mask first, router too long, dns twice (first wins)
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        add_opt(KIND_MASK, 8'd0, 32'd0);
        add_opt(KIND_MASK, LEN_ADDR, 32'hFFFF_0000);
        add_opt(KIND_ROUTER, 8'd5, $urandom);
        add_opt(KIND_DNS, LEN_ADDR, 32'h0101_0101);
        add_opt(KIND_DNS, LEN_ADDR, 32'h0202_0202);
        send_frame($urandom);
        // ack with dns cut off inside its data
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        add_opt(KIND_DNS, LEN_ADDR, $urandom);
        void'(frame.pop_back());
        send_frame($urandom);
        // ack with mask cut off at its length byte
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        frame.push_back(KIND_MASK);
        frame.push_back(LEN_ADDR);
        send_frame($urandom);
        // header check failures: op, xid, cookie in the wrong byte order
        start_frame(8'd1, xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        send_frame($urandom);
        start_frame(OP_REPLY, xid_reg ^ 32'h8000_0000, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_OFFER);
        send_frame($urandom);
        start_frame(OP_REPLY, xid_reg, $urandom, 32'h6353_8263);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_OFFER);
        send_frame($urandom);
        // short packets: one byte, one byte short of the header, bare header
        frame.delete();
        frame.push_back(OP_REPLY);
        send_frame($urandom);
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        void'(frame.pop_back());
        send_frame($urandom);
        start_frame(OP_REPLY, xid_reg, $urandom, MAGIC_COOKIE);
        send_frame($urandom);
        // long packet: more than 255 option bytes before the offer
        start_frame(OP_REPLY, xid_reg, 32'h1234_5678, MAGIC_COOKIE);
        add_pads(300);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_OFFER);
        add_opt(KIND_LEASE, LEN_ADDR, 32'hFFFF_FFFF);
        send_frame(32'h5555_AAAA);
        // ack after that offer reports the kept server and lease
        start_frame(OP_REPLY, xid_reg, 32'h1234_5678, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        add_opt(8'd200, 8'd255, 32'd0);
        repeat (155) void'(frame.pop_back());
        send_frame($urandom);
        // options still walked behind a failed header
        start_frame(OP_REPLY, ~xid_reg, $urandom, MAGIC_COOKIE);
        add_opt(KIND_TYPE, LEN_TYPE, MSG_ACK);
        add_opt(KIND_MASK, LEN_ADDR, $urandom);
        send_frame($urandom);
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the xid register first
        directed_frames();

        write_xid(32'hFFFF_FFFF);
        random_phase(500, 12);

        write_xid($urandom);
        random_phase(500, 12);

        // long receiver hold while back-to-back final bytes keep arriving
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        @(negedge clk);
        repeat (40) begin
            frame.delete();
            add_noise($urandom_range(1, 2));
            send_frame($urandom);
        end
        wait_drained();

        write_xid(32'h0000_0000);
        random_phase(500, 12);

        // closing stretch without any idling
        @(posedge clk);
        calm <= 1'b1;
        write_xid($urandom);
        random_phase(400, 10);

        if (errors == 0)
            $display("dhcp_reply_parser_core regression: pass");
        else
            $display("dhcp_reply_parser_core regression: fail");
        $finish;
    end

endmodule
